// ===== src/srmc_pkg.sv =====
// srmc_pkg: shared types, constants and a helper function for the stepper ramp controller.
// Used by srmc_div and stepper_ramp_controller; depends on nothing else.
package srmc_pkg;

  // Transfer payloads
  typedef struct packed {
    logic               func;
    logic signed [15:0] step_count;
    logic [31:0]        now_us;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  coil_pattern;
    logic        stepped;
    logic [15:0] steps_remaining;
    logic [11:0] position;
  } out_item_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_STEPS_PER_REV = 2'd0;
  localparam logic [1:0] CFG_SPEED_RPM     = 2'd1;
  localparam logic [1:0] CFG_FOUR_WIRE     = 2'd2;

  localparam logic [12:0] RST_STEPS_PER_REV = 13'd200;
  localparam logic [9:0]  RST_SPEED_RPM     = 10'd60;

  // Command codes
  localparam logic FUNC_MOVE = 1'b0;

  // Divider geometry: 26-bit dividend (60e6 fits), 13-bit divisor, 2 bits per cycle
  localparam int DIV_W     = 26;
  localparam int DIVISOR_W = 13;
  localparam int DIV_ITER  = DIV_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_ITER);

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // Ramp constants
  localparam logic [DIV_W-1:0] US_PER_MIN  = 26'd60000000;
  localparam logic [15:0]      SMALL_STEPS = 16'd300;
  localparam logic [12:0]      RAMP_BASE   = 13'd4;
  // x/100 == (x*5243) >> 19 exactly for x < 43690
  localparam logic [12:0]      RECIP_100   = 13'd5243;
  localparam int               RECIP_SHIFT = 19;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD,
    ST_SPD,
    ST_DIV1,
    ST_DIV2,
    ST_STEP,
    ST_FIN
  } state_e;

  // Coil drive for a phase; 2-wire: 2,3,1,0 and 4-wire: 5,6,10,9
  function automatic logic [3:0] coil_pattern_f(input logic four_wire, input logic [1:0] phase);
    logic [3:0] pat;
    pat = 4'd0;
    if (four_wire) begin
      unique case (phase)
        2'd0: pat = 4'd5;
        2'd1: pat = 4'd6;
        2'd2: pat = 4'd10;
        2'd3: pat = 4'd9;
      endcase
    end else begin
      unique case (phase)
        2'd0: pat = 4'd2;
        2'd1: pat = 4'd3;
        2'd2: pat = 4'd1;
        2'd3: pat = 4'd0;
      endcase
    end
    return pat;
  endfunction

endpackage

// ===== src/srmc_div.sv =====
// srmc_div: shared restoring divider, two quotient bits per cycle.
// Depends on srmc_pkg for widths and the request/response structs.
module srmc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srmc_pkg::div_req_t req_i,
  output srmc_pkg::div_rsp_t rsp_o
);
  import srmc_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [DIVISOR_W-1:0] dsr_q, dsr_d;
  logic [DIVISOR_W-1:0] rem_mid;
  logic                 qb_hi, qb_lo;

  // One restoring step: shift in a dividend bit, subtract if it fits
  function automatic logic [DIVISOR_W:0] div_step(input logic [DIVISOR_W-1:0] rem,
                                                  input logic bit_in,
                                                  input logic [DIVISOR_W-1:0] dsr);
    logic [DIVISOR_W:0] t;
    logic               fits;
    t    = {rem, bit_in};
    fits = (t >= {1'b0, dsr});
    if (fits) t = t - {1'b0, dsr};
    return {fits, t[DIVISOR_W-1:0]};
  endfunction

  // Two chained steps per cycle
  always_comb begin
    {qb_hi, rem_mid} = div_step(rem_q, quo_q[DIV_W-1], dsr_q);
    {qb_lo, rem_d}   = div_step(rem_mid, quo_q[DIV_W-2], dsr_q);
  end

  // Iteration control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[DIV_W-3:0], qb_hi, qb_lo};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_ITER - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    dsr_q <= dsr_d;
    if (req_i.start) rem_q <= '0;
    else if (busy_q) rem_q <= rem_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== src/stepper_ramp_controller.sv =====
// stepper_ramp_controller: top level, sequencer, ramp speed pick and step datapath.
// Depends on srmc_pkg and srmc_div (shared serial divider).
//
//   port group | direction | handshake          | payload
//   in         | input     | in_valid/in_stall  | func, step_count, now_us
//   out        | output    | out_valid/out_stall| coil_pattern, stepped, steps_remaining, position
//   cfg        | input     | cfg_we             | cfg_addr, cfg_wdata
//
// A poll with steps remaining passes the command and speed states, two passes through
// the shared divider (60e6/steps_per_rev, then /speed), then the step and finish states.
// A poll with nothing remaining goes from the speed state straight to the finish state.
// in_stall_o is high while an item is in work; a finished result waits in the output
// register, so the next item may be taken while out_stall_i holds it. Reset clears the
// control and motor state and drives no coils.
module stepper_ramp_controller #(
  parameter int MAX_STEPS_PER_REV = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  srmc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output srmc_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_addr_i,
  input  logic [12:0]         cfg_wdata_i
);
  import srmc_pkg::*;

  localparam int REV_MAX = (MAX_STEPS_PER_REV < 8191) ? MAX_STEPS_PER_REV : 8191;
  localparam int POS_W   = $clog2(REV_MAX);

  // Configuration
  logic [12:0] steps_per_rev_q;
  logic [9:0]  speed_rpm_q;
  logic        four_wire_q;

  // State
  state_e            state_q, state_d;
  logic [15:0]       remaining_q;
  logic [15:0]       total_q;
  logic              forward_q;
  logic [POS_W-1:0]  step_pos_q;
  logic [31:0]       last_step_q;
  logic [3:0]        drive_q;
  logic              stepped_q;
  in_item_t          item_q;
  logic [DIVISOR_W-1:0] speed_q;
  logic [DIV_W-1:0]  delay_q;
  logic              out_valid_q;
  out_item_t         out_q;

  // Control
  logic     accept;
  logic     out_load;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Datapath nets
  logic [12:0]          rev_n;
  logic [15:0]          move_mag;
  logic [17:0]          rem_x4, tot_x3;
  logic [15:0]          done_cnt, ramp_x;
  logic [28:0]          ramp_prod;
  logic [DIVISOR_W-1:0] speed_d;
  logic [31:0]          elapsed;
  logic                 step_due;
  logic [13:0]          pos_w;
  logic [POS_W-1:0]     pos_next;

  assign accept = in_valid_i && !in_stall_o;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_per_rev_q <= RST_STEPS_PER_REV;
      speed_rpm_q     <= RST_SPEED_RPM;
      four_wire_q     <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_STEPS_PER_REV: steps_per_rev_q <= cfg_wdata_i;
        CFG_SPEED_RPM:     speed_rpm_q     <= cfg_wdata_i[9:0];
        CFG_FOUR_WIRE:     four_wire_q     <= cfg_wdata_i[0];
        default:           ;
      endcase
    end
  end

  // Effective steps per revolution: 0 -> 1, saturate at the maximum
  always_comb begin
    if (steps_per_rev_q == '0) rev_n = 13'd1;
    else if (steps_per_rev_q > 13'(REV_MAX)) rev_n = 13'(REV_MAX);
    else rev_n = steps_per_rev_q;
  end

  // Magnitude of the signed step count
  assign move_mag = item_q.step_count[15] ? (~item_q.step_count + 16'd1)
                                          : item_q.step_count;

  // Ramp speed pick
  always_comb begin
    rem_x4    = {remaining_q, 2'b00};
    tot_x3    = {1'b0, total_q, 1'b0} + {2'b00, total_q};
    done_cnt  = (total_q >= remaining_q) ? (total_q - remaining_q) : 16'd0;
    ramp_x    = (remaining_q < SMALL_STEPS) ? remaining_q : done_cnt;
    ramp_prod = 29'(ramp_x) * 29'(RECIP_100);
    if (remaining_q < SMALL_STEPS || rem_x4 >= tot_x3) begin
      speed_d = 13'(ramp_prod[28:RECIP_SHIFT]) + RAMP_BASE;
    end else if (speed_rpm_q == '0) begin
      speed_d = 13'd1;
    end else begin
      speed_d = 13'(speed_rpm_q);
    end
  end

  // Step decision and next position
  always_comb begin
    elapsed  = item_q.now_us - last_step_q;
    step_due = (elapsed >= 32'(delay_q));
    pos_w    = 14'(step_pos_q);
    if (forward_q) begin
      if (pos_w + 14'd1 >= {1'b0, rev_n}) pos_next = '0;
      else pos_next = step_pos_q + 1'b1;
    end else begin
      if (step_pos_q == '0 || pos_w >= {1'b0, rev_n}) pos_next = POS_W'(rev_n - 13'd1);
      else pos_next = step_pos_q - 1'b1;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_CMD;
      ST_CMD:  state_d = ST_SPD;
      ST_SPD:  state_d = (remaining_q == '0) ? ST_FIN : ST_DIV1;
      ST_DIV1: if (div_rsp.done) state_d = ST_DIV2;
      ST_DIV2: if (div_rsp.done) state_d = ST_STEP;
      ST_STEP: state_d = ST_FIN;
      ST_FIN:  if (out_load) state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o       = (state_q != ST_IDLE);
    out_load         = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
    div_req.start    = 1'b0;
    div_req.dividend = US_PER_MIN;
    div_req.divisor  = rev_n;
    unique case (state_q)
      ST_SPD:  div_req.start = (remaining_q != '0);
      ST_DIV1: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = div_rsp.quotient;
        div_req.divisor  = speed_q;
      end
      default: ;
    endcase
  end

  srmc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Control and motor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      remaining_q <= '0;
      total_q     <= '0;
      forward_q   <= 1'b0;
      step_pos_q  <= '0;
      last_step_q <= '0;
      drive_q     <= '0;
      stepped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CMD) begin
        stepped_q <= 1'b0;
        if (item_q.func == FUNC_MOVE) begin
          remaining_q <= move_mag;
          total_q     <= move_mag;
          if (item_q.step_count[15]) forward_q <= 1'b0;
          else if (item_q.step_count != '0) forward_q <= 1'b1;
        end
      end
      if (state_q == ST_STEP && step_due) begin
        stepped_q   <= 1'b1;
        last_step_q <= item_q.now_us;
        step_pos_q  <= pos_next;
        remaining_q <= remaining_q - 16'd1;
        drive_q     <= coil_pattern_f(four_wire_q, pos_next[1:0]);
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_data_i;
    if (state_q == ST_SPD) speed_q <= speed_d;
    if (state_q == ST_DIV2 && div_rsp.done) delay_q <= div_rsp.quotient;
    if (out_load) begin
      out_q.coil_pattern    <= drive_q;
      out_q.stepped         <= stepped_q;
      out_q.steps_remaining <= remaining_q;
      out_q.position        <= 12'(step_pos_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== tb/stepper_ramp_controller_test.sv =====
`timescale 1ns / 1ps
// stepper_ramp_controller_test: self-checking bench for the stepper ramp controller.
// Predicts every result from its own motor model; depends on srmc_pkg and the RTL.
module stepper_ramp_controller_test;
  import srmc_pkg::*;

  // Motor and bench constants
  localparam logic        FUNC_POLL        = 1'b1;
  localparam logic [1:0]  CFG_SPARE        = 2'd3;
  localparam int unsigned REV_MAX          = 4096;
  localparam int unsigned NEAR_END         = 300;
  localparam int unsigned RAMP_STEP        = 100;
  localparam int unsigned RAMP_MIN         = 4;
  localparam int unsigned USEC_PER_MIN     = 60000000;
  // longest delay a move can see on its first poll: one step per rev at 4 rpm
  localparam int unsigned LONGEST_START_US = 15000000;
  localparam int unsigned HOLD_CYCLES      = 400;
  localparam int unsigned SETTLE_CYCLES    = 40;
  localparam int unsigned CYCLE_LIMIT      = 400000;
  // coil drive by phase, phase 0 in the low nibble
  localparam logic [15:0] TWO_WIRE_SEQ     = {4'd0, 4'd1, 4'd3, 4'd2};
  localparam logic [15:0] FOUR_WIRE_SEQ    = {4'd9, 4'd10, 4'd6, 4'd5};

  // When a poll is timed relative to the last step
  typedef enum logic [1:0] {
    AT_DUE,
    TOO_EARLY,
    ANY_TIME
  } when_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  in_item_t    in_data_i   = '0;
  logic        out_stall_i = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_addr_i  = '0;
  logic [12:0] cfg_wdata_i = '0;
  logic        in_stall_o;
  logic        out_valid_o;
  out_item_t   out_data_o;

  // Motor model state and register copies
  int unsigned mot_left    = 0;
  int unsigned mot_total   = 0;
  logic        mot_fwd     = 1'b0;
  int unsigned mot_pos     = 0;
  logic [31:0] mot_last_us = '0;
  logic [3:0]  mot_coils   = '0;
  logic [12:0] reg_rev     = RST_STEPS_PER_REV;
  logic [9:0]  reg_rpm     = RST_SPEED_RPM;
  logic        reg_four    = 1'b1;

  out_item_t   expected_drive_q[$];
  int unsigned n_items     = 0;
  int unsigned n_steps     = 0;
  int unsigned n_writes    = 0;
  int unsigned n_mismatch  = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned rx_burst    = 0;
  logic        rx_hold     = 1'b0;
  logic        idle_on     = 1'b1;
  event        hold_ev;

  stepper_ramp_controller u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_drive_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Motor model
  // ---------------------------------------------------------------------------
  function automatic int unsigned rev_count();
    if (reg_rev == 0) return 1;
    if (reg_rev > REV_MAX) return REV_MAX;
    return 32'(reg_rev);
  endfunction

  // trapezoid: slow start, cruise, slow finish
  function automatic int unsigned ramp_rpm();
    if (mot_left < NEAR_END) return mot_left / RAMP_STEP + RAMP_MIN;
    if (4 * mot_left >= 3 * mot_total)
      return ((mot_total >= mot_left) ? mot_total - mot_left : 0) / RAMP_STEP + RAMP_MIN;
    return (reg_rpm == 0) ? 1 : 32'(reg_rpm);
  endfunction

  function automatic int unsigned step_delay_us();
    return (USEC_PER_MIN / rev_count()) / ramp_rpm();
  endfunction

  // Apply one command to the motor model, return the drive status it leaves
  function automatic out_item_t advance_motor(input in_item_t it);
    out_item_t   res;
    logic [15:0] raw;
    logic [31:0] lag;
    int unsigned n;
    int unsigned ph;
    logic        took;
    raw  = it.step_count;
    took = 1'b0;
    if (it.func == FUNC_MOVE) begin
      if (raw[15]) begin
        mot_left = 32'h10000 - 32'(raw);
        mot_fwd  = 1'b0;
      end else begin
        mot_left = 32'(raw);
        if (raw != 0) mot_fwd = 1'b1;
      end
      mot_total = mot_left;
    end
    if (mot_left != 0) begin
      n   = rev_count();
      lag = it.now_us - mot_last_us;
      if (lag >= step_delay_us()) begin
        took        = 1'b1;
        mot_last_us = it.now_us;
        if (mot_fwd) mot_pos = (mot_pos + 1 >= n) ? 0 : mot_pos + 1;
        else mot_pos = (mot_pos == 0 || mot_pos >= n) ? n - 1 : mot_pos - 1;
        mot_left--;
        ph        = mot_pos % 4;
        mot_coils = reg_four ? FOUR_WIRE_SEQ[ph*4 +: 4] : TWO_WIRE_SEQ[ph*4 +: 4];
        n_steps++;
      end
    end
    res.coil_pattern    = mot_coils;
    res.stepped         = took;
    res.steps_remaining = mot_left[15:0];
    res.position        = mot_pos[11:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: stall pacing, long hold, result check
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rx_burst != 0) rx_burst--;
    else if (idle_on && $urandom_range(0, 5) == 0) rx_burst = $urandom_range(1, 12);
    out_stall_i <= rx_hold || (rx_burst != 0);
  end

  initial begin : rx_long_hold
    forever begin
      @(hold_ev);
      @(posedge clk_i);
      rx_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      rx_hold = 1'b0;
    end
  end

  task automatic report_miss(input string what, input out_item_t want, input out_item_t got);
    n_mismatch++;
    if (n_mismatch <= 10)
      $display("%s: expected coil=%h step=%0d left=%0d pos=%0d, got coil=%h step=%0d left=%0d pos=%0d",
               what, want.coil_pattern, want.stepped, want.steps_remaining, want.position,
               got.coil_pattern, got.stepped, got.steps_remaining, got.position);
  endtask

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_drive_q.size() == 0) begin
        report_miss("result with nothing expected", '0, out_data_o);
      end else begin
        want = expected_drive_q.pop_front();
        if (out_data_o.coil_pattern !== want.coil_pattern ||
            out_data_o.stepped !== want.stepped ||
            out_data_o.steps_remaining !== want.steps_remaining ||
            out_data_o.position !== want.position)
          report_miss("drive status mismatch", want, out_data_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side and register writes
  // ---------------------------------------------------------------------------
  task automatic send_xfer(input in_item_t it);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    expected_drive_q.push_back(advance_motor(it));
    n_items++;
  endtask

  function automatic in_item_t mk_item(input logic fn, input logic [15:0] cnt,
                                       input logic [31:0] now);
    in_item_t it;
    it.func       = fn;
    it.step_count = cnt;
    it.now_us     = now;
    return it;
  endfunction

  function automatic when_e pick_when();
    int unsigned r;
    r = $urandom_range(0, 9);
    return (r < 8) ? AT_DUE : (r < 9) ? TOO_EARLY : ANY_TIME;
  endfunction

  task automatic send_move(input logic [15:0] cnt, input when_e when);
    logic [31:0] now;
    case (when)
      AT_DUE:    now = mot_last_us + LONGEST_START_US + $urandom_range(0, 999);
      TOO_EARLY: now = mot_last_us;
      default:   now = $urandom();
    endcase
    send_xfer(mk_item(FUNC_MOVE, cnt, now));
  endtask

  task automatic send_poll(input when_e when);
    logic [31:0] now;
    case (when)
      AT_DUE:    now = mot_last_us + step_delay_us() + $urandom_range(0, 3);
      TOO_EARLY: now = mot_last_us + step_delay_us() - 1 - $urandom_range(0, 3);
      default:   now = $urandom();
    endcase
    send_xfer(mk_item(FUNC_POLL, 16'($urandom_range(0, 65535)), now));
  endtask

  // sender pauses until every result is back and the block is quiet
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_drive_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_STEPS_PER_REV: reg_rev  = val;
      CFG_SPEED_RPM:     reg_rpm  = val[9:0];
      CFG_FOUR_WIRE:     reg_four = val[0];
      default: ;
    endcase
    n_writes++;
  endtask

  // one move with random content followed by a few polls, or a stray item
  task automatic random_sequence();
    int unsigned pick;
    logic [15:0] cnt;
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      if (pick == 0) send_poll(ANY_TIME);
      else send_xfer(mk_item(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                             $urandom()));
      return;
    end
    cnt = (pick < 12) ? 16'($urandom_range(1, 40)) :
          (pick < 15) ? 16'($urandom_range(41, 700)) :
          (pick < 17) ? 16'd0 : 16'($urandom_range(0, 65535));
    if (pick < 15 && $urandom_range(0, 1) == 1) cnt = -cnt;
    send_move(cnt, ($urandom_range(0, 7) == 0) ? TOO_EARLY : AT_DUE);
    repeat ($urandom_range(1, 14)) send_poll(pick_when());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // idle polls, zero count, both directions, count extremes, time wrap
  task automatic test_moves_directed();
    send_xfer(mk_item(FUNC_POLL, 16'h7FFF, 32'h0000_0000));
    send_xfer(mk_item(FUNC_POLL, 16'h8000, 32'hFFFF_FFFF));
    send_move(16'd0, AT_DUE);
    send_move(16'd3, AT_DUE);
    send_poll(TOO_EARLY);
    send_poll(AT_DUE);
    send_poll(AT_DUE);
    send_poll(AT_DUE);
    send_move(16'hFFFE, AT_DUE);
    send_poll(AT_DUE);
    send_xfer(mk_item(FUNC_MOVE, 16'd5, 32'hFFFF_FF00));
    send_poll(AT_DUE);
    send_move(16'h7FFF, AT_DUE);
    send_poll(AT_DUE);
    send_move(16'h8000, AT_DUE);
    send_poll(AT_DUE);
    send_move(16'hFFFF, AT_DUE);
    send_move(16'd0, ANY_TIME);
    drain();
  endtask

  // 2-wire drive; the held pattern only follows the select on a step
  task automatic test_coil_select();
    write_reg(CFG_FOUR_WIRE, 13'd0);
    send_poll(AT_DUE);
    send_move(16'd4, AT_DUE);
    repeat (3) send_poll(AT_DUE);
    drain();
    write_reg(CFG_FOUR_WIRE, 13'd1);
  endtask

  // steps per rev at zero and above the maximum, position left beyond the rev
  task automatic test_rev_limits();
    write_reg(CFG_STEPS_PER_REV, 13'd0);
    send_move(16'd2, AT_DUE);
    send_poll(AT_DUE);
    drain();
    write_reg(CFG_STEPS_PER_REV, 13'h1FFF);
    send_move(16'hFFFF, AT_DUE);
    drain();
    write_reg(CFG_STEPS_PER_REV, 13'd200);
    send_move(16'd1, AT_DUE);
    drain();
    write_reg(CFG_STEPS_PER_REV, 13'd4096);
    send_move(16'hFFFF, AT_DUE);
    drain();
    write_reg(CFG_STEPS_PER_REV, 13'd200);
    send_move(16'hFFFF, AT_DUE);
    drain();
    write_reg(CFG_SPARE, 13'($urandom_range(0, 8191)));
  endtask

  // a move long enough to ramp up, cruise a few steps and start slowing
  task automatic test_ramp_profile(input logic [12:0] rev, input logic [12:0] rpm);
    write_reg(CFG_STEPS_PER_REV, rev);
    write_reg(CFG_SPEED_RPM, rpm);
    send_move(($urandom_range(0, 1) == 1) ? 16'd404 : -16'd404, AT_DUE);
    while (mot_left >= 296) send_poll(($urandom_range(0, 9) == 0) ? TOO_EARLY : AT_DUE);
    drain();
  endtask

  // output held for a long stretch while commands keep coming
  task automatic test_back_pressure();
    -> hold_ev;
    send_move(16'd60, AT_DUE);
    repeat (9) send_poll(AT_DUE);
    drain();
  endtask

  task automatic test_random_traffic();
    int unsigned goal;
    int unsigned sel;
    repeat (4) begin
      sel = $urandom_range(0, 5);
      write_reg(CFG_STEPS_PER_REV, (sel == 0) ? 13'd0 :
                                   (sel == 1) ? 13'($urandom_range(4097, 8191)) :
                                   13'($urandom_range(1, 4096)));
      write_reg(CFG_SPEED_RPM, ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 8191)) :
                               13'($urandom_range(1, 1000)));
      write_reg(CFG_FOUR_WIRE, 13'($urandom_range(0, 8191)));
      idle_on = ($urandom_range(0, 3) != 0);
      goal = n_items + 50;
      while (n_items < goal) random_sequence();
      drain();
    end
  endtask

  // last stretch without any idling on either side
  task automatic test_quiet_tail();
    int unsigned goal;
    idle_on = 1'b0;
    write_reg(CFG_STEPS_PER_REV, 13'($urandom_range(1, 400)));
    write_reg(CFG_SPEED_RPM, 13'($urandom_range(1, 1000)));
    goal = n_items + 40;
    while (n_items < goal) random_sequence();
    drain();
  endtask

  initial begin : run
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_moves_directed();
    test_coil_select();
    test_rev_limits();
    test_ramp_profile(13'd4096, 13'd0);
    test_ramp_profile(13'd1, 13'd1023);
    test_back_pressure();
    test_random_traffic();
    test_quiet_tail();
    $display("Ran %0d commands over %0d register writes; %0d motor steps, %0d mismatches.",
             n_items, n_writes, n_steps, n_mismatch);
    $display("Covered idle polls, ramp up/cruise/slow down, rev limits, coil modes, long hold.");
    if (n_mismatch == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
